### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, gated off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/clv_pkg.sv
// ----------------------------------------------------------------------------
// clv_pkg
// Shared constants, status codes and result type of the capability-list
// validator.
// ----------------------------------------------------------------------------
package clv_pkg;

  localparam int unsigned MAX_SETS   = 32;
  localparam int unsigned SET_IDX_W  = 5;   // width of set_index
  localparam int unsigned SET_CNT_W  = 6;   // width of the set counter and set_total
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned TOTAL_SAT  = 63;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam logic KIND_DESC   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_SHORT_LEN = 3'd3,
    ST_DUP_TYPE  = 3'd4,
    ST_TRAILING  = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_e;

  typedef struct packed {
    logic                 kind;
    logic [SET_IDX_W-1:0] set_index;
    logic [WORD_W-1:0]    set_type;
    logic [WORD_W-1:0]    data_offset;
    logic [WORD_W-1:0]    data_length;
    logic [STATUS_W-1:0]  status;
    logic [SET_CNT_W-1:0] set_total;
    logic                 run_end;
  } clv_result_t;

  // Parser to type store: write of a new type, and duplicate lookup.
  typedef struct packed {
    logic                 we;
    logic [SET_IDX_W-1:0] waddr;
    logic [WORD_W-1:0]    wtype;
    logic [WORD_W-1:0]    qtype;
    logic [SET_CNT_W-1:0] qcount;
  } clv_store_req_t;

endpackage

### design/clv_in_if.sv
// ----------------------------------------------------------------------------
// clv_in_if
// Byte stream channel into the validator.
// ----------------------------------------------------------------------------
interface clv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

### design/clv_out_if.sv
// ----------------------------------------------------------------------------
// clv_out_if
// Result channel out of the validator.
// ----------------------------------------------------------------------------
interface clv_out_if;
  import clv_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SET_IDX_W-1:0] set_index;
  logic [WORD_W-1:0]    set_type;
  logic [WORD_W-1:0]    data_offset;
  logic [WORD_W-1:0]    data_length;
  logic [STATUS_W-1:0]  status;
  logic [SET_CNT_W-1:0] set_total;
  logic                 run_end;

  modport source (output valid, output kind, output set_index, output set_type,
                  output data_offset, output data_length, output status,
                  output set_total, output run_end, input ready);
  modport sink   (input valid, input kind, input set_index, input set_type,
                  input data_offset, input data_length, input status,
                  input set_total, input run_end, output ready);
endinterface

### design/clv_type_store.sv
// ----------------------------------------------------------------------------
// clv_type_store
// Types seen in the current message; parallel duplicate compare.
// ----------------------------------------------------------------------------
module clv_type_store (
  input  logic                    clk_i,
  input  clv_pkg::clv_store_req_t req_i,
  output logic                    dup_o
);
  import clv_pkg::*;

  logic [WORD_W-1:0]   types_q [MAX_SETS];
  logic [MAX_SETS-1:0] hit;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      types_q[req_i.waddr] <= req_i.wtype;
    end
  end

  // Only entries written earlier in this message take part.
  always_comb begin
    for (int j = 0; j < MAX_SETS; j++) begin
      hit[j] = (SET_CNT_W'(j) < req_i.qcount) && (types_q[j] == req_i.qtype);
    end
  end

  assign dup_o = |hit;

endmodule

### design/clv_parse.sv
// ----------------------------------------------------------------------------
// clv_parse
// Message state machine: decodes one byte per fire, emits up to two results.
// ----------------------------------------------------------------------------
module clv_parse (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [7:0]              byte_i,
  input  logic                    final_i,
  input  logic                    dup_i,
  output clv_pkg::clv_store_req_t store_o,
  output logic [1:0]              push_cnt_o,
  output clv_pkg::clv_result_t    res0_o,
  output clv_pkg::clv_result_t    res1_o
);
  import clv_pkg::*;

  typedef enum logic [1:0] {
    PH_LIST_HDR,
    PH_SET_HDR,
    PH_DATA,
    PH_DONE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [1:0]           pos_q, pos_d;
  logic [WORD_W-1:0]    count_q, count_d;
  logic [SET_CNT_W-1:0] sets_q, sets_d;
  logic [WORD_W-1:0]    type_q, type_d;
  logic [WORD_W-1:0]    len_q, len_d;
  logic [WORD_W-1:0]    left_q, left_d;
  logic [WORD_W-1:0]    off_q, off_d;
  logic [STATUS_W-1:0]  err_q, err_d;

  logic [WORD_W-1:0]    full_len;
  logic [WORD_W-1:0]    new_left;
  logic [SET_CNT_W-1:0] sets_inc;
  logic                 desc;
  logic [STATUS_W-1:0]  fin_status;
  logic [SET_CNT_W-1:0] fin_total;
  clv_result_t          desc_res, stat_res;

  assign full_len = {byte_i, len_q[7:0]};
  assign new_left = full_len - WORD_W'(HDR_BYTES);
  assign sets_inc = sets_q + SET_CNT_W'(1);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    count_d = count_q;
    sets_d  = sets_q;
    type_d  = type_q;
    len_d   = len_q;
    left_d  = left_q;
    err_d   = err_q;
    desc    = 1'b0;
    store_o.we     = 1'b0;
    store_o.waddr  = sets_q[SET_IDX_W-1:0];
    store_o.wtype  = type_q;
    store_o.qtype  = type_q;
    store_o.qcount = sets_q;

    if (err_d == ST_OK && off_q == '1) begin
      err_d = ST_TOO_LONG;
    end

    if (err_d == ST_OK) begin
      case (phase_q)
        PH_LIST_HDR: begin
          if (pos_q == 2'd0) count_d = {8'h00, byte_i};
          else if (pos_q == 2'd1) count_d = {byte_i, count_q[7:0]};
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            sets_d = '0;
            if (count_q > WORD_W'(MAX_SETS)) err_d = ST_TOO_MANY;
            phase_d = (count_q == '0) ? PH_DONE : PH_SET_HDR;
          end
        end
        PH_SET_HDR: begin
          if (pos_q == 2'd0) type_d = {8'h00, byte_i};
          else if (pos_q == 2'd1) type_d = {byte_i, type_q[7:0]};
          else if (pos_q == 2'd2) len_d = {8'h00, byte_i};
          else len_d = full_len;
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            if (full_len < WORD_W'(HDR_BYTES)) begin
              err_d = ST_SHORT_LEN;
            end else if (dup_i) begin
              err_d = ST_DUP_TYPE;
            end else begin
              store_o.we = fire_i && (sets_q < SET_CNT_W'(MAX_SETS));
              left_d = new_left;
              desc   = 1'b1;
              sets_d = sets_inc;
              if (new_left != '0) phase_d = PH_DATA;
              else if ({{(WORD_W-SET_CNT_W){1'b0}}, sets_inc} >= count_q) phase_d = PH_DONE;
              else phase_d = PH_SET_HDR;
            end
          end
        end
        PH_DATA: begin
          if (left_q != '0) left_d = left_q - WORD_W'(1);
          if (left_d == '0) begin
            phase_d = ({{(WORD_W-SET_CNT_W){1'b0}}, sets_q} >= count_q) ? PH_DONE
                                                                       : PH_SET_HDR;
          end
        end
        default: begin
          err_d = ST_TRAILING;
        end
      endcase
    end

    off_d = (off_q == '1) ? off_q : off_q + WORD_W'(1);

    fin_status = err_d;
    if (err_d == ST_OK && phase_d != PH_DONE) fin_status = ST_TRUNC;
    if (phase_d == PH_LIST_HDR) fin_total = '0;
    else if (count_d > WORD_W'(TOTAL_SAT)) fin_total = SET_CNT_W'(TOTAL_SAT);
    else fin_total = count_d[SET_CNT_W-1:0];

    if (final_i) begin
      phase_d = PH_LIST_HDR;
      pos_d   = '0;
      count_d = '0;
      sets_d  = '0;
      type_d  = '0;
      len_d   = '0;
      left_d  = '0;
      off_d   = '0;
      err_d   = ST_OK;
    end
  end

  always_comb begin
    desc_res             = '0;
    desc_res.kind        = KIND_DESC;
    desc_res.set_index   = sets_q[SET_IDX_W-1:0];
    desc_res.set_type    = type_q;
    desc_res.data_offset = off_q + WORD_W'(1);
    desc_res.data_length = new_left;
    desc_res.run_end     = !final_i;

    stat_res             = '0;
    stat_res.kind        = KIND_STATUS;
    stat_res.status      = fin_status;
    stat_res.set_total   = fin_total;
    stat_res.run_end     = 1'b1;

    res0_o     = desc ? desc_res : stat_res;
    res1_o     = stat_res;
    push_cnt_o = '0;
    if (fire_i) push_cnt_o = {1'b0, desc} + {1'b0, final_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LIST_HDR;
      pos_q   <= '0;
      count_q <= '0;
      sets_q  <= '0;
      type_q  <= '0;
      len_q   <= '0;
      left_q  <= '0;
      off_q   <= '0;
      err_q   <= ST_OK;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      sets_q  <= sets_d;
      type_q  <= type_d;
      len_q   <= len_d;
      left_q  <= left_d;
      off_q   <= off_d;
      err_q   <= err_d;
    end
  end

endmodule

### design/clv_result_fifo.sv
// ----------------------------------------------------------------------------
// clv_result_fifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module clv_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  clv_pkg::clv_result_t wdata0_i,
  input  clv_pkg::clv_result_t wdata1_i,
  input  logic                 pop_i,
  output clv_pkg::clv_result_t rdata_o,
  output logic                 not_empty_o,
  output logic                 room2_o
);
  import clv_pkg::*;

  clv_result_t        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic [FIFO_AW-1:0] wptr_nx;

  assign wptr_nx     = wptr_q + FIFO_AW'(1);
  assign not_empty_o = (cnt_q != '0);
  assign room2_o     = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign rdata_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wptr_q] <= wdata0_i;
    if (push_cnt_i == 2'd2) mem_q[wptr_nx] <= wdata1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FIFO_AW'(push_cnt_i);
      if (pop_i) rptr_q <= rptr_q + FIFO_AW'(1);
      cnt_q <= cnt_q + FIFO_CW'(push_cnt_i) - FIFO_CW'(pop_i);
    end
  end

endmodule

### design/capability_list_tlv_validator.sv
// ----------------------------------------------------------------------------
// capability_list_tlv_validator
// Capability-list parser with per-set descriptors and a final status.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle, back to back, unless the input stalls
// (only while the queue holds more than two results). Each byte is captured
// in an input register and decoded from there against the parser state; a
// complete set header yields a descriptor, the final byte a status, and the
// results go through a four-entry queue that delivers one per cycle while
// the receiver is ready. A final byte that also closes a set header makes
// two results, queued together and delivered one after the other. Duplicate
// types are found by a combinational compare with this message's types.
module capability_list_tlv_validator (
  input  logic              clk_i,
  input  logic              rst_ni,
  clv_in_if.sink            in_i,
  clv_out_if.source         out_o
);
  import clv_pkg::*;

  logic           vld_q;
  logic [7:0]     byte_q;
  logic           fin_q;
  logic           fire;
  logic           room2;
  logic           not_empty;
  logic           dup;
  logic [1:0]     push_cnt;
  clv_store_req_t store_req;
  clv_result_t    res0, res1, head;

  assign fire       = vld_q && room2;
  assign in_i.ready = !vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.byte_in;
      fin_q  <= in_i.final_byte;
    end
  end

  clv_type_store u_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .dup_o (dup)
  );

  clv_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .final_i    (fin_q),
    .dup_i      (dup),
    .store_o    (store_req),
    .push_cnt_o (push_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  clv_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .wdata0_i    (res0),
    .wdata1_i    (res1),
    .pop_i       (not_empty && out_o.ready),
    .rdata_o     (head),
    .not_empty_o (not_empty),
    .room2_o     (room2)
  );

  assign out_o.valid       = not_empty;
  assign out_o.kind        = head.kind;
  assign out_o.set_index   = head.set_index;
  assign out_o.set_type    = head.set_type;
  assign out_o.data_offset = head.data_offset;
  assign out_o.data_length = head.data_length;
  assign out_o.status      = head.status;
  assign out_o.set_total   = head.set_total;
  assign out_o.run_end     = head.run_end;

endmodule

### design/clv_checker.sv
// ----------------------------------------------------------------------------
// clv_checker
// Port-level checks on the validator's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          kind_i,
  input logic [clv_pkg::WORD_W-1:0]    data_offset_i,
  input logic [clv_pkg::STATUS_W-1:0]  status_i,
  input logic [clv_pkg::SET_CNT_W-1:0] set_total_i,
  input logic                          run_end_i
);
  import clv_pkg::*;

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // The status item always closes the results of its byte.
  `ASSERT_IMPLY(a_status_last, clk_i, rst_ni, out_valid_i && kind_i == KIND_STATUS, run_end_i)

  // A clean message never declares more sets than the store holds.
  `ASSERT_IMPLY(a_ok_total, clk_i, rst_ni,
    out_valid_i && kind_i == KIND_STATUS && status_i == ST_OK,
    set_total_i <= SET_CNT_W'(MAX_SETS))

  // Set data starts after the list header and one set header.
  `ASSERT_IMPLY(a_desc_offset, clk_i, rst_ni, out_valid_i && kind_i == KIND_DESC,
    data_offset_i >= WORD_W'(2 * HDR_BYTES))

endmodule

bind capability_list_tlv_validator clv_checker u_clv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .data_offset_i (out_o.data_offset),
  .status_i      (out_o.status),
  .set_total_i   (out_o.set_total),
  .run_end_i     (out_o.run_end)
);

### tb/tb_capability_list_tlv_validator.sv
// ----------------------------------------------------------------------------
// tb_capability_list_tlv_validator
// Self-checking bench for the capability-list validator.
// ----------------------------------------------------------------------------
// A queue of message bytes feeds a falling-edge driver; a rising-edge monitor
// runs every accepted byte through a parser model of its own and checks each
// descriptor and status against the oldest predicted one. Messages are mostly
// well formed with random content, plus truncated, oversized-count, short-set,
// duplicate-type, trailing-byte and noise messages, and one message past the
// 64 KiB limit. Both sides idle at random; the receiver holds off once.
module tb_capability_list_tlv_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import clv_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned RANDOM_BYTES   = 1070;
  localparam int unsigned HOLD_AFTER     = 200;

  typedef enum logic [1:0] {
    PH_LIST_HDR,
    PH_SET_HDR,
    PH_DATA,
    PH_DONE
  } parse_phase_e;

  typedef enum int {
    MSG_GOOD,
    MSG_TRUNC,
    MSG_TOO_MANY,
    MSG_SHORT_LEN,
    MSG_DUP,
    MSG_TRAIL,
    MSG_NOISE
  } msg_shape_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       no_gap;
  } byte_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  clv_in_if  in_if ();
  clv_out_if out_if ();

  capability_list_tlv_validator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser model state
  parse_phase_e ph;
  logic [1:0]   fpos;
  logic [15:0]  cnt;
  logic [5:0]   done_sets;
  logic [15:0]  cur_type;
  logic [15:0]  cur_len;
  logic [15:0]  left;
  logic [15:0]  offs;
  status_e      err;
  logic [15:0]  types_seen [MAX_SETS];

  byte_item_t   byte_stream [$];
  clv_result_t  awaited_results [$];
  byte_item_t   next_item;
  clv_result_t  got;

  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned bytes_queued   = 0;
  int unsigned msgs_built     = 0;
  int unsigned total_bytes    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  bit          in_taken       = 0;
  bit          hold_req       = 0;
  bit          send_calm      = 0;
  bit          recv_calm      = 0;

  task automatic clear_msg();
    ph        = PH_LIST_HDR;
    fpos      = '0;
    cnt       = '0;
    done_sets = '0;
    cur_type  = '0;
    cur_len   = '0;
    left      = '0;
    offs      = '0;
    err       = ST_OK;
  endtask

  function automatic parse_phase_e phase_after_set();
    return (done_sets >= cnt) ? PH_DONE : PH_SET_HDR;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    clv_result_t r;
    clv_result_t res [$];
    bit          dup;
    if (err == ST_OK && offs == 16'hFFFF) err = ST_TOO_LONG;
    if (err == ST_OK) begin
      case (ph)
        PH_LIST_HDR: begin
          if (fpos == 2'd0) cnt = {8'h00, b};
          else if (fpos == 2'd1) cnt[15:8] = b;
          if (fpos == 2'd3) begin
            done_sets = '0;
            if (cnt > MAX_SETS) err = ST_TOO_MANY;
            ph = phase_after_set();
          end
          fpos = fpos + 2'd1;
        end
        PH_SET_HDR: begin
          case (fpos)
            2'd0:    cur_type = {8'h00, b};
            2'd1:    cur_type[15:8] = b;
            2'd2:    cur_len = {8'h00, b};
            default: cur_len[15:8] = b;
          endcase
          if (fpos == 2'd3) begin
            dup = 0;
            for (int j = 0; j < done_sets; j++)
              if (types_seen[j] == cur_type) dup = 1;
            if (cur_len < HDR_BYTES) begin
              err = ST_SHORT_LEN;
            end else if (dup) begin
              err = ST_DUP_TYPE;
            end else begin
              types_seen[done_sets[SET_IDX_W-1:0]] = cur_type;
              left = cur_len - 16'(HDR_BYTES);
              r = '0;
              r.kind        = KIND_DESC;
              r.set_index   = done_sets[SET_IDX_W-1:0];
              r.set_type    = cur_type;
              r.data_offset = offs + 16'd1;
              r.data_length = left;
              res.push_back(r);
              done_sets = done_sets + 6'd1;
              ph = (left == 16'd0) ? phase_after_set() : PH_DATA;
            end
          end
          fpos = fpos + 2'd1;
        end
        PH_DATA: begin
          if (left != 16'd0) left = left - 16'd1;
          if (left == 16'd0) ph = phase_after_set();
        end
        default: err = ST_TRAILING;
      endcase
    end
    if (offs != 16'hFFFF) offs = offs + 16'd1;
    if (fin) begin
      r = '0;
      r.kind   = KIND_STATUS;
      r.status = (err == ST_OK && ph != PH_DONE) ? ST_TRUNC : err;
      // total stays zero if the list header never completed
      if (ph != PH_LIST_HDR)
        r.set_total = (cnt > TOTAL_SAT) ? SET_CNT_W'(TOTAL_SAT) : cnt[SET_CNT_W-1:0];
      res.push_back(r);
      clear_msg();
    end
    if (res.size() > 0) res[res.size()-1].run_end = 1'b1;
    foreach (res[i]) awaited_results.push_back(res[i]);
  endtask

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] g, input logic [15:0] w);
    if (g !== w)
      report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, name, g, w));
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Monitor: input acceptance feeds the model, output acceptance is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        parse_byte(in_if.byte_in, in_if.final_byte);
        bytes_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.kind, out_if.set_index, out_if.set_type, out_if.data_offset,
               out_if.data_length, out_if.status, out_if.set_total, out_if.run_end};
        if (awaited_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing predicted", results_seen));
        end else begin
          check_field("kind", 16'(got.kind), 16'(awaited_results[0].kind));
          check_field("set_index", 16'(got.set_index), 16'(awaited_results[0].set_index));
          check_field("set_type", got.set_type, awaited_results[0].set_type);
          check_field("data_offset", got.data_offset, awaited_results[0].data_offset);
          check_field("data_length", got.data_length, awaited_results[0].data_length);
          check_field("status", 16'(got.status), 16'(awaited_results[0].status));
          check_field("set_total", 16'(got.set_total), 16'(awaited_results[0].set_total));
          check_field("run_end", 16'(got.run_end), 16'(awaited_results[0].run_end));
          void'(awaited_results.pop_front());
        end
        results_seen++;
        idle_cycles = 0;
      end else if (in_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Byte driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      if (!in_if.valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          next_item = byte_stream.pop_front();
          in_if.byte_in    <= next_item.data;
          in_if.final_byte <= next_item.last;
          in_if.valid      <= 1'b1;
          gap_left = next_item.no_gap ? 0 : pick_gap(send_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(recv_calm);
      end
    end
  end

  task automatic queue_message(ref logic [7:0] m [$], input bit quiet);
    foreach (m[i])
      byte_stream.push_back('{data: m[i], last: (i == m.size() - 1), no_gap: quiet});
    if (!quiet) bytes_queued += m.size();
    msgs_built++;
  endtask

  // Bytes are given first byte in the top of the used part of the vector
  task automatic directed_message(input logic [63:0] bytes, input int unsigned n);
    logic [7:0] m [$];
    for (int i = 0; i < n; i++) m.push_back(bytes[8*(n-1-i) +: 8]);
    queue_message(m, 0);
  endtask

  function automatic int unsigned pick_set_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 12);
    return MAX_SETS;
  endfunction

  function automatic int unsigned pick_data_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 85) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 40);
    return $urandom_range(41, 300);
  endfunction

  function automatic logic [15:0] pick_big_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'(MAX_SETS + 1);
    if (r < 60) return 16'd64;
    if (r < 80) return 16'($urandom_range(34, 255));
    if (r < 92) return 16'($urandom_range(256, 65534));
    return 16'hFFFF;
  endfunction

  function automatic msg_shape_e pick_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return MSG_GOOD;
    if (r < 65) return MSG_TRUNC;
    if (r < 71) return MSG_TOO_MANY;
    if (r < 77) return MSG_SHORT_LEN;
    if (r < 85) return MSG_DUP;
    if (r < 92) return MSG_TRAIL;
    return MSG_NOISE;
  endfunction

  task automatic build_message(input msg_shape_e shape);
    logic [7:0]  m [$];
    logic [15:0] types [$];
    logic [15:0] t;
    logic [15:0] len;
    logic [15:0] count;
    int unsigned nsets;
    int unsigned dlen;
    int unsigned victim;
    int unsigned cut;
    bit          fresh;
    nsets = pick_set_count();
    if (shape == MSG_DUP && nsets < 2) nsets = 2;
    if (shape == MSG_SHORT_LEN && nsets < 1) nsets = 1;
    victim = $urandom_range(0, (nsets == 0) ? 0 : nsets - 1);
    if (shape == MSG_DUP && victim == 0) victim = 1;
    count = (shape == MSG_TOO_MANY) ? pick_big_count() : 16'(nsets);
    if (shape == MSG_NOISE) begin
      repeat ($urandom_range(1, 12)) m.push_back(8'($urandom));
    end else begin
      m.push_back(count[7:0]);
      m.push_back(count[15:8]);
      m.push_back(8'($urandom));
      m.push_back(8'($urandom));
      if (shape == MSG_TOO_MANY) begin
        repeat ($urandom_range(0, 5)) m.push_back(8'($urandom));
      end else begin
        for (int s = 0; s < nsets; s++) begin
          if (shape == MSG_DUP && s == victim) begin
            t = types[$urandom_range(0, s - 1)];
          end else begin
            do begin
              t = 16'($urandom);
              fresh = 1;
              foreach (types[k]) if (types[k] == t) fresh = 0;
            end while (!fresh);
          end
          types.push_back(t);
          dlen = pick_data_len();
          len = 16'(dlen + HDR_BYTES);
          if (shape == MSG_SHORT_LEN && s == victim) len = 16'($urandom_range(0, 3));
          m.push_back(t[7:0]);
          m.push_back(t[15:8]);
          m.push_back(len[7:0]);
          m.push_back(len[15:8]);
          repeat (dlen) m.push_back(8'($urandom));
        end
      end
      if (shape == MSG_TRAIL) repeat ($urandom_range(1, 3)) m.push_back(8'($urandom));
      if (shape == MSG_TRUNC) begin
        cut = $urandom_range(1, m.size() - 1);
        while (m.size() > cut) void'(m.pop_back());
      end
    end
    queue_message(m, 0);
  endtask

  // One set of the largest length: the byte limit trips before its data ends
  task automatic build_long_message();
    logic [7:0] m [$];
    m = '{8'h01, 8'h00, 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom), 8'hFF, 8'hFF};
    repeat (16'hFFFF - HDR_BYTES) m.push_back(8'($urandom));
    queue_message(m, 1);
  endtask

  initial begin
    int unsigned start;
    bit          long_done;
    in_if.valid      = 1'b0;
    in_if.byte_in    = '0;
    in_if.final_byte = 1'b0;
    out_if.ready     = 1'b0;
    clear_msg();

    // lone final byte, count over the limit, short set length,
    // trailing byte after an empty list, final byte that closes a set header
    directed_message(64'hFF, 1);
    directed_message(64'h2100_FFFF, 4);
    directed_message(64'h0100_0000_0000_0300, 8);
    directed_message(64'h00_0012_345A, 5);
    directed_message(64'h0100_A5A5_FFFF_0400, 8);

    start = bytes_queued;
    long_done = 0;
    while (bytes_queued - start < RANDOM_BYTES) begin
      if (!long_done && bytes_queued - start > RANDOM_BYTES / 2) begin
        build_long_message();
        long_done = 1;
      end
      build_message(pick_shape());
    end
    total_bytes = byte_stream.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (bytes_accepted < HOLD_AFTER) @(posedge clk_i);
    hold_req = 1;

    while (bytes_accepted < total_bytes) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report($sformatf("%0d predicted results never arrived", awaited_results.size()));

    $display("Ran %0d messages, %0d bytes, one past the 64 KiB limit, with a %0d-cycle",
             msgs_built, bytes_accepted, HOLD_CYCLES);
    $display("output hold-off; checked %0d descriptors and status results", results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
